// ===== rtl/core/nce_pkg.sv =====
// Package for the nibble CPU execute block.
// Holds the decoded-op types, the result record and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nce_pkg;

    localparam int RAM_DEPTH = 256;
    localparam int IN_PORTS  = 4;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int MOD_RECIP = 65536 / RAM_DEPTH;

    localparam logic [3:0] MAJ_ADD_A   = 4'h0;
    localparam logic [3:0] MAJ_MOV_AB  = 4'h1;
    localparam logic [3:0] MAJ_IN_A    = 4'h2;
    localparam logic [3:0] MAJ_MOV_A   = 4'h3;
    localparam logic [3:0] MAJ_MOV_BA  = 4'h4;
    localparam logic [3:0] MAJ_ADD_B   = 4'h5;
    localparam logic [3:0] MAJ_IN_B    = 4'h6;
    localparam logic [3:0] MAJ_MOV_B   = 4'h7;
    localparam logic [3:0] MAJ_GROUP   = 4'h8;
    localparam logic [3:0] MAJ_OUT_B   = 4'h9;
    localparam logic [3:0] MAJ_JZ      = 4'hA;
    localparam logic [3:0] MAJ_OUT_IM  = 4'hB;
    localparam logic [3:0] MAJ_Y_IM    = 4'hC;
    localparam logic [3:0] MAJ_X_IM    = 4'hD;
    localparam logic [3:0] MAJ_JNC     = 4'hE;
    localparam logic [3:0] MAJ_JMP     = 4'hF;

    localparam logic [3:0] SUB_ADD_AB  = 4'h0;
    localparam logic [3:0] SUB_NEG     = 4'h1;
    localparam logic [3:0] SUB_NOT     = 4'h2;
    localparam logic [3:0] SUB_OR      = 4'h3;
    localparam logic [3:0] SUB_AND     = 4'h4;
    localparam logic [3:0] SUB_XOR     = 4'h5;
    localparam logic [3:0] SUB_SUB     = 4'h6;
    localparam logic [3:0] SUB_OUT_A   = 4'h7;
    localparam logic [3:0] SUB_LD_A    = 4'h8;
    localparam logic [3:0] SUB_ST_A    = 4'h9;
    localparam logic [3:0] SUB_LD_B    = 4'hA;
    localparam logic [3:0] SUB_ST_B    = 4'hB;
    localparam logic [3:0] SUB_X_A     = 4'hC;
    localparam logic [3:0] SUB_Y_A     = 4'hD;
    localparam logic [3:0] SUB_INC_XY  = 4'hE;
    localparam logic [3:0] SUB_JMP_XY  = 4'hF;

    typedef enum logic [4:0] {
        OP_ADD_A_IM,
        OP_MOV_A_B_IM,
        OP_IN_A,
        OP_MOV_A_IM,
        OP_MOV_B_A_IM,
        OP_ADD_B_IM,
        OP_IN_B,
        OP_MOV_B_IM,
        OP_ADD_AB,
        OP_NEG,
        OP_NOT,
        OP_OR,
        OP_AND,
        OP_XOR,
        OP_SUB,
        OP_OUT_A,
        OP_LD_A,
        OP_ST_A,
        OP_LD_B,
        OP_ST_B,
        OP_X_A,
        OP_Y_A,
        OP_INC_XY,
        OP_JMP_XY,
        OP_OUT_B_IM,
        OP_JZ,
        OP_OUT_IM,
        OP_Y_IM,
        OP_X_IM,
        OP_JNC,
        OP_JMP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [3:0] im;
        logic       zen;
    } dec_t;

    typedef struct packed {
        logic       valid;
        dec_t       op;
    } dq_head_t;

    typedef struct packed {
        logic [7:0] next_pc;
        logic [3:0] reg_a;
        logic [3:0] reg_b;
        logic [7:0] xy_pointer;
        logic [4:0] out_port;
        logic       carry_flag;
        logic       zero_flag;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/nibble_cpu_instruction_execute.sv =====
// Nibble CPU instruction execute unit: the input-port configuration register
// plus the decoding front end and the execute back end. Depends on nce_pkg,
// nce_front and nce_back.
//
// Usage:
//   Instructions enter through a queue-style port: a byte transfers on a
//   rising edge with push high and full low. Results leave the same way:
//   while empty is low the ports show the oldest result (PC, A, B, XY, OUT,
//   C, Z after that instruction); it transfers on an edge with pop high.
//   The input-port value is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no instruction is pending.
//   Throughput: one instruction per cycle while the result queue is not
//   full, set by the single execute stage that updates the registers and
//   reads or writes the data RAM. Each side has a two-entry queue, so full
//   rises only after the result side has stalled long enough to fill both;
//   no result is ever dropped. Reset clears all registers, flags, the input
//   index and marks every RAM entry as zero at once; the block accepts an
//   instruction right after.
`timescale 1ns / 1ps
`default_nettype none

module nibble_cpu_instruction_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  instruction,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       next_pc,
    output logic [3:0]       reg_a,
    output logic [3:0]       reg_b,
    output logic [7:0]       xy_pointer,
    output logic [4:0]       out_port,
    output logic             carry_flag,
    output logic             zero_flag,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import nce_pkg::*;

    logic [15:0] input_nibbles_reg;
    dq_head_t    head;
    logic        head_pop;
    res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_nibbles_reg <= 16'h0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            input_nibbles_reg <= cfg_data;
        end
    end

    nce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .instruction (instruction),
        .head        (head),
        .head_pop    (head_pop)
    );

    nce_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_pop      (head_pop),
        .input_nibbles (input_nibbles_reg),
        .empty         (empty),
        .pop           (pop),
        .res_out       (res)
    );

    assign next_pc    = res.next_pc;
    assign reg_a      = res.reg_a;
    assign reg_b      = res.reg_b;
    assign xy_pointer = res.xy_pointer;
    assign out_port   = res.out_port;
    assign carry_flag = res.carry_flag;
    assign zero_flag  = res.zero_flag;

endmodule

`default_nettype wire

// ===== rtl/core/nce_front.sv =====
// Front end: accepts instruction bytes, decodes them and queues the decoded ops.
// Depends on nce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nce_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      instruction,
    output nce_pkg::dq_head_t    head,
    input  wire logic            head_pop
);
    import nce_pkg::*;

    dec_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       wr_en;
    logic       rd_en;
    dec_t       dec;

    function automatic dec_t decode(input logic [7:0] code);
        dec_t       d;
        logic [3:0] im;
        logic       im_nz;
        im     = code[3:0];
        im_nz  = (im != 4'h0);
        d.im   = im;
        d.zen  = 1'b1;
        d.kind = OP_JMP;
        case (code[7:4])
            MAJ_ADD_A:  d.kind = OP_ADD_A_IM;
            MAJ_MOV_AB: begin d.kind = OP_MOV_A_B_IM; d.zen = im_nz; end
            MAJ_IN_A:   begin d.kind = OP_IN_A;       d.zen = im_nz; end
            MAJ_MOV_A:  begin d.kind = OP_MOV_A_IM;   d.zen = 1'b0;  end
            MAJ_MOV_BA: begin d.kind = OP_MOV_B_A_IM; d.zen = im_nz; end
            MAJ_ADD_B:  begin d.kind = OP_ADD_B_IM;   d.zen = im_nz; end
            MAJ_IN_B:   begin d.kind = OP_IN_B;       d.zen = im_nz; end
            MAJ_MOV_B:  d.kind = OP_MOV_B_IM;
            MAJ_GROUP:
            begin
                case (im)
                    SUB_ADD_AB: d.kind = OP_ADD_AB;
                    SUB_NEG:    d.kind = OP_NEG;
                    SUB_NOT:    d.kind = OP_NOT;
                    SUB_OR:     d.kind = OP_OR;
                    SUB_AND:    d.kind = OP_AND;
                    SUB_XOR:    d.kind = OP_XOR;
                    SUB_SUB:    d.kind = OP_SUB;
                    SUB_OUT_A:  begin d.kind = OP_OUT_A;  d.zen = 1'b0; end
                    SUB_LD_A:   begin d.kind = OP_LD_A;   d.zen = 1'b0; end
                    SUB_ST_A:   begin d.kind = OP_ST_A;   d.zen = 1'b0; end
                    SUB_LD_B:   begin d.kind = OP_LD_B;   d.zen = 1'b0; end
                    SUB_ST_B:   begin d.kind = OP_ST_B;   d.zen = 1'b0; end
                    SUB_X_A:    begin d.kind = OP_X_A;    d.zen = 1'b0; end
                    SUB_Y_A:    begin d.kind = OP_Y_A;    d.zen = 1'b0; end
                    SUB_INC_XY: begin d.kind = OP_INC_XY; d.zen = 1'b0; end
                    SUB_JMP_XY: d.kind = OP_JMP_XY;
                    default:    d.kind = OP_JMP_XY;
                endcase
            end
            MAJ_OUT_B:  begin d.kind = OP_OUT_B_IM; d.zen = 1'b0; end
            MAJ_JZ:     d.kind = OP_JZ;
            MAJ_OUT_IM: begin d.kind = OP_OUT_IM;   d.zen = 1'b0; end
            MAJ_Y_IM:   begin d.kind = OP_Y_IM;     d.zen = 1'b0; end
            MAJ_X_IM:   begin d.kind = OP_X_IM;     d.zen = 1'b0; end
            MAJ_JNC:    d.kind = OP_JNC;
            MAJ_JMP:    d.kind = OP_JMP;
            default:    d.kind = OP_JMP;
        endcase
        return d;
    endfunction

    assign dec        = decode(instruction);
    assign full       = (count_reg == 2'd2);
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.op    = slot_reg[rptr_reg];

    // hold decoded ops until the back end takes them
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd_en)
            begin
                rptr_reg <= !rptr_reg;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nce_back.sv =====
// Back end: architectural registers, data RAM, execute logic and result queue.
// Depends on nce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nce_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire nce_pkg::dq_head_t head,
    output logic                 head_pop,
    input  wire logic [15:0]     input_nibbles,
    output logic                 empty,
    input  wire logic            pop,
    output nce_pkg::res_t        res_out
);
    import nce_pkg::*;

    localparam logic [1:0] IDX_LAST = 2'(IN_PORTS - 1);

    logic [3:0]        a_reg, a_next;
    logic [3:0]        b_reg, b_next;
    logic [7:0]        xy_reg, xy_next;
    logic [7:0]        pc_reg, pc_next;
    logic              c_reg, c_next;
    logic              z_reg, z_next;
    logic [4:0]        out_reg, out_next;
    logic [1:0]        idx_reg, idx_next;

    logic [3:0]        mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] valid_reg;
    logic [3:0]        rd_data_reg;
    logic              hit_reg;
    logic              fwd_reg;
    logic [3:0]        fwd_data_reg;
    logic [RAM_AW-1:0] addr_reg;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        xy_follow;
    logic [3:0]        ram_value;
    logic              wr_en;
    logic [3:0]        wr_data;

    res_t              q_reg [2];
    logic              qw_reg;
    logic              qr_reg;
    logic [1:0]        qcount_reg;
    logic              q_full;
    logic              fire;
    logic              q_rd;

    logic [7:0]        result;
    logic              jump;
    logic [3:0]        port_val;
    logic [1:0]        idx_adv;
    logic [7:0]        pc_inc;
    res_t              res_new;

    function automatic logic [RAM_AW-1:0] ram_index(input logic [7:0] xy);
        logic [23:0] prod;
        logic [7:0]  quo;
        logic [15:0] rem;
        prod = 24'(xy) * 24'(MOD_RECIP);
        quo  = prod[23:16];
        rem  = 16'(xy) - 16'(quo) * 16'(RAM_DEPTH);
        if (rem >= 16'(RAM_DEPTH))
        begin
            rem = rem - 16'(RAM_DEPTH);
        end
        return rem[RAM_AW-1:0];
    endfunction

    assign q_full   = (qcount_reg == 2'd2);
    assign fire     = head.valid && !q_full;
    assign head_pop = fire;
    assign empty    = (qcount_reg == 2'd0);
    assign q_rd     = pop && !empty;
    assign res_out  = q_reg[qr_reg];

    assign port_val  = input_nibbles[{idx_reg, 2'b00} +: 4];
    assign idx_adv   = (idx_reg == IDX_LAST) ? 2'd0 : idx_reg + 2'd1;
    assign pc_inc    = pc_reg + 8'd1;
    assign ram_value = fwd_reg ? fwd_data_reg : (hit_reg ? rd_data_reg : 4'h0);

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        xy_next  = xy_reg;
        pc_next  = pc_reg;
        c_next   = c_reg;
        z_next   = z_reg;
        out_next = out_reg;
        idx_next = idx_reg;
        result   = 8'h00;
        jump     = 1'b0;
        wr_en    = 1'b0;
        wr_data  = a_reg;
        case (head.op.kind)
            OP_ADD_A_IM:   begin result = 8'(a_reg) + 8'(head.op.im); a_next = result[3:0]; end
            OP_MOV_A_B_IM: begin result = 8'(b_reg) + 8'(head.op.im); a_next = result[3:0]; end
            OP_IN_A:
            begin
                result   = 8'(port_val) + 8'(head.op.im);
                a_next   = result[3:0];
                idx_next = idx_adv;
            end
            OP_MOV_A_IM:   a_next = head.op.im;
            OP_MOV_B_A_IM: begin result = 8'(a_reg) + 8'(head.op.im); b_next = result[3:0]; end
            OP_ADD_B_IM:   begin result = 8'(b_reg) + 8'(head.op.im); b_next = result[3:0]; end
            OP_IN_B:
            begin
                result   = 8'(port_val) + 8'(head.op.im);
                b_next   = result[3:0];
                idx_next = idx_adv;
            end
            OP_MOV_B_IM:   b_next = head.op.im;
            OP_ADD_AB:     begin result = 8'(a_reg) + 8'(b_reg); a_next = result[3:0]; end
            OP_NEG:        begin result = {4'h0, 4'h0 - a_reg}; a_next = result[3:0]; end
            OP_NOT:        begin result = {4'hF, ~a_reg}; a_next = result[3:0]; end
            OP_OR:         begin result = {4'h0, a_reg | b_reg}; a_next = result[3:0]; end
            OP_AND:        begin result = {4'h0, a_reg & b_reg}; a_next = result[3:0]; end
            OP_XOR:        begin result = {4'h0, a_reg ^ b_reg}; a_next = result[3:0]; end
            OP_SUB:        begin result = 8'(a_reg) - 8'(b_reg); a_next = result[3:0]; end
            OP_OUT_A:      out_next = 5'(a_reg);
            OP_LD_A:       a_next = ram_value;
            OP_ST_A:       begin wr_en = 1'b1; wr_data = a_reg; end
            OP_LD_B:       b_next = ram_value;
            OP_ST_B:       begin wr_en = 1'b1; wr_data = b_reg; end
            OP_X_A:        xy_next = {a_reg, xy_reg[3:0]};
            OP_Y_A:        xy_next = {xy_reg[7:4], a_reg};
            OP_INC_XY:     xy_next = xy_reg + 8'd1;
            OP_JMP_XY:     begin pc_next = xy_reg; jump = 1'b1; end
            OP_OUT_B_IM:   out_next = 5'(b_reg) + 5'(head.op.im);
            OP_JZ:
            begin
                pc_next = z_reg ? {pc_reg[7:4], head.op.im} : pc_inc;
                jump    = 1'b1;
            end
            OP_OUT_IM:     out_next = 5'(head.op.im);
            OP_Y_IM:       xy_next = {xy_reg[7:4], head.op.im};
            OP_X_IM:       xy_next = {head.op.im, xy_reg[3:0]};
            OP_JNC:
            begin
                pc_next = c_reg ? pc_inc : {pc_reg[7:4], head.op.im};
                jump    = 1'b1;
            end
            OP_JMP:        begin pc_next = {pc_reg[7:4], head.op.im}; jump = 1'b1; end
            default:       begin pc_next = {pc_reg[7:4], head.op.im}; jump = 1'b1; end
        endcase
        if (!jump)
        begin
            c_next  = (result[7:4] != 4'h0);
            z_next  = (result[3:0] == 4'h0) && head.op.zen;
            pc_next = pc_inc;
        end
    end

    assign res_new.next_pc    = pc_next;
    assign res_new.reg_a      = a_next;
    assign res_new.reg_b      = b_next;
    assign res_new.xy_pointer = xy_next;
    assign res_new.out_port   = out_next;
    assign res_new.carry_flag = c_next;
    assign res_new.zero_flag  = z_next;

    // read the entry that XY will point at next cycle
    assign xy_follow = fire ? xy_next : xy_reg;
    assign rd_addr   = ram_index(xy_follow);

    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
        if (fire)
        begin
            q_reg[qw_reg] <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= 4'h0;
            b_reg      <= 4'h0;
            xy_reg     <= 8'h00;
            pc_reg     <= 8'h00;
            c_reg      <= 1'b0;
            z_reg      <= 1'b0;
            out_reg    <= 5'h00;
            idx_reg    <= 2'd0;
            valid_reg  <= '0;
            hit_reg    <= 1'b0;
            fwd_reg    <= 1'b0;
            addr_reg   <= '0;
            qw_reg     <= 1'b0;
            qr_reg     <= 1'b0;
            qcount_reg <= 2'd0;
        end
        else
        begin
            if (fire)
            begin
                a_reg   <= a_next;
                b_reg   <= b_next;
                xy_reg  <= xy_next;
                pc_reg  <= pc_next;
                c_reg   <= c_next;
                z_reg   <= z_next;
                out_reg <= out_next;
                idx_reg <= idx_next;
                qw_reg  <= !qw_reg;
                if (wr_en)
                begin
                    valid_reg[addr_reg] <= 1'b1;
                end
            end
            addr_reg <= rd_addr;
            hit_reg  <= valid_reg[rd_addr];
            fwd_reg  <= fire && wr_en && (addr_reg == rd_addr);
            if (q_rd)
            begin
                qr_reg <= !qr_reg;
            end
            case ({fire, q_rd})
                2'b10:   qcount_reg <= qcount_reg + 2'd1;
                2'b01:   qcount_reg <= qcount_reg - 2'd1;
                default: qcount_reg <= qcount_reg;
            endcase
        end
    end

endmodule

`default_nettype wire
